@@ rtl/pec_pkg.sv @@
// ----------------------------------------------------------------------------
// pec_pkg
// shared types, constants and tables of the pair-event cut histogrammer
// ----------------------------------------------------------------------------
package pec_pkg;

	// field widths
	localparam int OP_W       = 2;
	localparam int ENERGY_W   = 16;
	localparam int SUM_W      = 17;
	localparam int COS_W      = 17;
	localparam int POLAR_W    = 12;
	localparam int AZ_W       = 13;
	localparam int BIN_IDX_W  = 6;
	localparam int CNT_OUT_W  = 32;
	localparam int ASY_W      = 16;
	localparam int DIFF_W     = 18;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// opcodes
	localparam logic [OP_W-1:0] OP_ACC   = 2'd0;
	localparam logic [OP_W-1:0] OP_READ  = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
	localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ENERGY_MIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SUM_LOW     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SUM_HIGH    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BIN_WIDTH   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DIFF_OFFSET = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_COS_OUTER   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_COS_INNER   = 3'd6;

	// register reset values
	localparam logic [ENERGY_W-1:0] RST_ENERGY_MIN  = 16'd10;
	localparam logic [SUM_W-1:0]    RST_SUM_LOW     = 17'd5800;
	localparam logic [SUM_W-1:0]    RST_SUM_HIGH    = 17'd6000;
	localparam logic [ENERGY_W-1:0] RST_BIN_WIDTH   = 16'd400;
	localparam logic [SUM_W-1:0]    RST_DIFF_OFFSET = 17'd6000;
	localparam logic [COS_W-1:0]    RST_COS_OUTER   = 17'd64332;
	localparam logic [COS_W-1:0]    RST_COS_INNER   = 17'd64729;

	// parameter defaults
	localparam int DEF_NUM_BINS     = 30;
	localparam int DEF_COUNT_WIDTH  = 32;
	localparam int DEF_CORDIC_STEPS = 18;

	// angle arithmetic, Q30 radians
	localparam int ANG_W  = 36;
	localparam int XY_W   = 34;
	localparam int CS_W   = 32;
	localparam int STEP_W = 5;
	localparam int MAG_W  = 14;
	localparam logic signed [ANG_W-1:0] Q30_PI      = 36'sd3373259426;
	localparam logic signed [ANG_W-1:0] Q30_HALF_PI = 36'sd1686629713;
	localparam logic signed [ANG_W-1:0] Q30_TWO_PI  = 36'sd6746518852;
	localparam logic signed [XY_W-1:0]  CORDIC_GAIN = 34'sd652032874;

	// mrad * 2^30 / 1000 = mag*MRAD_HI + floor(mag*MRAD_LO/125)
	localparam logic [20:0] MRAD_HI     = 21'd1073741;
	localparam logic [6:0]  MRAD_LO     = 7'd103;
	localparam logic [20:0] RECIP_125   = 21'd1073742;
	localparam int          RECIP_SHIFT = 27;

	// shared divider
	localparam int DIV_NUM_W = 47;
	localparam int DIV_DEN_W = 33;

	localparam logic [ASY_W-1:0] ASY_MAX = 16'd32767;
	localparam logic [COS_W-1:0] COS_ONE = 17'd65536;

	typedef struct packed {
		logic [ENERGY_W-1:0] energy_min;
		logic [SUM_W-1:0]    sum_low;
		logic [SUM_W-1:0]    sum_high;
		logic [ENERGY_W-1:0] bin_width;
		logic [SUM_W-1:0]    diff_offset;
		logic [COS_W-1:0]    cos_outer;
		logic [COS_W-1:0]    cos_inner;
	} cfg_t;

	typedef struct packed {
		logic [OP_W-1:0]        opcode;
		logic                   source;
		logic [ENERGY_W-1:0]    positron_energy;
		logic [ENERGY_W-1:0]    electron_energy;
		logic [POLAR_W-1:0]     electron_polar;
		logic [POLAR_W-1:0]     positron_polar;
		logic signed [AZ_W-1:0] electron_azimuth;
		logic signed [AZ_W-1:0] positron_azimuth;
		logic [BIN_IDX_W-1:0]   bin_index;
		logic                   window_select;
	} cmd_t;

	// queue entry: command plus the front's classification
	typedef struct packed {
		cmd_t              cmd;
		logic              bin_go;
		logic [DIFF_W-1:0] diff;
	} ent_t;

	function automatic logic [29:0] atan_q30(input logic [STEP_W-1:0] i);
		logic [29:0] r;
		case (i)
			5'd0:  r = 30'd843314856;
			5'd1:  r = 30'd497837829;
			5'd2:  r = 30'd263043836;
			5'd3:  r = 30'd133525158;
			5'd4:  r = 30'd67021686;
			5'd5:  r = 30'd33543515;
			5'd6:  r = 30'd16775850;
			5'd7:  r = 30'd8388437;
			5'd8:  r = 30'd4194282;
			5'd9:  r = 30'd2097149;
			5'd10: r = 30'd1048575;
			5'd11: r = 30'd524287;
			5'd12: r = 30'd262143;
			5'd13: r = 30'd131071;
			5'd14: r = 30'd65535;
			5'd15: r = 30'd32767;
			5'd16: r = 30'd16383;
			5'd17: r = 30'd8191;
			5'd18: r = 30'd4095;
			5'd19: r = 30'd2047;
			5'd20: r = 30'd1023;
			5'd21: r = 30'd511;
			5'd22: r = 30'd255;
			5'd23: r = 30'd127;
			default: r = 30'd0;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/pec_ifs.sv @@
// ----------------------------------------------------------------------------
// pec interfaces
// item, result and configuration channels, valid/ready handshake
// ----------------------------------------------------------------------------
interface pec_item_if import pec_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [OP_W-1:0]        opcode;
	logic                   src;
	logic [ENERGY_W-1:0]    positron_energy;
	logic [ENERGY_W-1:0]    electron_energy;
	logic [POLAR_W-1:0]     electron_polar;
	logic [POLAR_W-1:0]     positron_polar;
	logic signed [AZ_W-1:0] electron_azimuth;
	logic signed [AZ_W-1:0] positron_azimuth;
	logic [BIN_IDX_W-1:0]   bin_index;
	logic                   window_select;

	modport source (output valid, opcode, src, positron_energy, electron_energy,
		electron_polar, positron_polar, electron_azimuth, positron_azimuth,
		bin_index, window_select, input ready);
	modport sink (input valid, opcode, src, positron_energy, electron_energy,
		electron_polar, positron_polar, electron_azimuth, positron_azimuth,
		bin_index, window_select, output ready);
endinterface

interface pec_result_if import pec_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    passed;
	logic [BIN_IDX_W-1:0]    bin_hit;
	logic                    near_angle;
	logic [COS_W-1:0]        opening_cosine;
	logic [CNT_OUT_W-1:0]    bin_count;
	logic signed [ASY_W-1:0] asymmetry;

	modport source (output valid, passed, bin_hit, near_angle, opening_cosine,
		bin_count, asymmetry, input ready);
	modport sink (input valid, passed, bin_hit, near_angle, opening_cosine,
		bin_count, asymmetry, output ready);
endinterface

interface pec_cfg_if import pec_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  idx;
	logic [CFG_DATA_W-1:0] wdata;

	modport source (output valid, idx, wdata, input ready);
	modport sink (input valid, idx, wdata, output ready);
endinterface

@@ rtl/pec_front.sv @@
// ----------------------------------------------------------------------------
// pec_front
// accepts item beats, classifies them against the energy cuts, two-entry queue
// ----------------------------------------------------------------------------
module pec_front import pec_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	pec_item_if.sink items,
	input  logic  pop,
	output ent_t  head,
	output logic  head_valid
);

	ent_t                  ent_mem_q [2];
	logic                  wr_ptr_q;
	logic                  rd_ptr_q;
	logic [1:0]            cnt_q;
	logic                  push;
	ent_t                  ent;
	logic [SUM_W-1:0]      esum;
	logic signed [DIFF_W:0] diff;

	assign items.ready = (cnt_q != 2'd2);
	assign push        = items.valid && items.ready;
	assign head        = ent_mem_q[rd_ptr_q];
	assign head_valid  = (cnt_q != 2'd0);

	always_comb begin
		ent.cmd.opcode           = items.opcode;
		ent.cmd.source           = items.src;
		ent.cmd.positron_energy  = items.positron_energy;
		ent.cmd.electron_energy  = items.electron_energy;
		ent.cmd.electron_polar   = items.electron_polar;
		ent.cmd.positron_polar   = items.positron_polar;
		ent.cmd.electron_azimuth = items.electron_azimuth;
		ent.cmd.positron_azimuth = items.positron_azimuth;
		ent.cmd.bin_index        = items.bin_index;
		ent.cmd.window_select    = items.window_select;
		esum = {1'b0, items.positron_energy} + {1'b0, items.electron_energy};
		diff = $signed({3'b000, items.electron_energy}) - $signed({3'b000, items.positron_energy})
			+ $signed({2'b00, cfg.diff_offset});
		// energy cuts, window, nonzero bin width, positive difference
		ent.bin_go = (items.positron_energy > cfg.energy_min)
			&& (items.electron_energy > cfg.energy_min)
			&& (esum > cfg.sum_low) && (esum < cfg.sum_high)
			&& (cfg.bin_width != '0) && (diff > 0);
		ent.diff = diff[DIFF_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_mem_q[wr_ptr_q] <= ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

@@ rtl/pec_cordic.sv @@
// ----------------------------------------------------------------------------
// pec_cordic
// iterative rotation-mode sine/cosine, wraps and folds the angle first
// ----------------------------------------------------------------------------
module pec_cordic import pec_pkg::*; #(
	parameter int STEPS = DEF_CORDIC_STEPS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic signed [ANG_W-1:0] z_in,
	output logic                   busy,
	output logic signed [CS_W-1:0] cos_out,
	output logic signed [CS_W-1:0] sin_out
);

	localparam logic [1:0] C_IDLE = 2'd0;
	localparam logic [1:0] C_WRAP = 2'd1;
	localparam logic [1:0] C_FOLD = 2'd2;
	localparam logic [1:0] C_ITER = 2'd3;
	localparam logic [STEP_W-1:0] LAST = STEP_W'(STEPS - 1);

	logic [1:0]              state_q;
	logic [STEP_W-1:0]       step_q;
	logic signed [ANG_W-1:0] z_q;
	logic signed [XY_W-1:0]  x_q;
	logic signed [XY_W-1:0]  y_q;
	logic                    neg_q;
	logic signed [XY_W-1:0]  xs;
	logic signed [XY_W-1:0]  ys;
	logic signed [ANG_W-1:0] atan;

	assign busy = (state_q != C_IDLE);
	assign xs   = x_q >>> step_q;
	assign ys   = y_q >>> step_q;
	assign atan = $signed({{(ANG_W-30){1'b0}}, atan_q30(step_q)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				C_IDLE: if (start) begin
					state_q <= C_WRAP;
				end
				C_WRAP: state_q <= C_FOLD;
				C_FOLD: begin
					state_q <= C_ITER;
					step_q  <= '0;
				end
				C_ITER: begin
					step_q <= step_q + 1'b1;
					if (step_q == LAST) begin
						state_q <= C_IDLE;
					end
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			C_IDLE: if (start) begin
				z_q <= z_in;
			end
			C_WRAP: begin
				if (z_q > Q30_PI) begin
					z_q <= z_q - Q30_TWO_PI;
				end else if (z_q < -Q30_PI) begin
					z_q <= z_q + Q30_TWO_PI;
				end
			end
			C_FOLD: begin
				// folding by pi flips the sign of both outputs
				x_q   <= CORDIC_GAIN;
				y_q   <= '0;
				neg_q <= (z_q > Q30_HALF_PI) || (z_q < -Q30_HALF_PI);
				if (z_q > Q30_HALF_PI) begin
					z_q <= z_q - Q30_PI;
				end else if (z_q < -Q30_HALF_PI) begin
					z_q <= z_q + Q30_PI;
				end
			end
			C_ITER: begin
				if (z_q >= 0) begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - atan;
				end else begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + atan;
				end
				if (step_q == LAST) begin
					if (z_q >= 0) begin
						cos_out <= neg_q ? CS_W'(ys - x_q) : CS_W'(x_q - ys);
						sin_out <= neg_q ? CS_W'(-(y_q + xs)) : CS_W'(y_q + xs);
					end else begin
						cos_out <= neg_q ? CS_W'(-(x_q + ys)) : CS_W'(x_q + ys);
						sin_out <= neg_q ? CS_W'(xs - y_q) : CS_W'(y_q - xs);
					end
				end
			end
			default: ;
		endcase
	end

endmodule

@@ rtl/pec_div.sv @@
// ----------------------------------------------------------------------------
// pec_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pec_div import pec_pkg::*; #(
	parameter int NUM_W = DIV_NUM_W,
	parameter int DEN_W = DIV_DEN_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic [NUM_W-1:0] quo,
	output logic [DEN_W-1:0] rem
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	assign busy  = (cnt_q != '0);
	assign quo   = quo_q;
	assign rem   = rem_q;
	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign fits  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(NUM_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy) begin
			quo_q <= {quo_q[NUM_W-2:0], fits};
			rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
		end
	end

endmodule

@@ rtl/pec_back.sv @@
// ----------------------------------------------------------------------------
// pec_back
// sequencer: opening cosine, binning, count stores, readout and result beat
// ----------------------------------------------------------------------------
module pec_back import pec_pkg::*; #(
	parameter int NUM_BINS     = DEF_NUM_BINS,
	parameter int COUNT_WIDTH  = DEF_COUNT_WIDTH,
	parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  ent_t  head,
	input  logic  head_valid,
	output logic  pop,
	pec_result_if.source results
);

	localparam int DEPTH  = 2 * NUM_BINS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_ANG_MUL  = 4'd1;
	localparam logic [3:0] S_ANG_SUM  = 4'd2;
	localparam logic [3:0] S_ANG_GO   = 4'd3;
	localparam logic [3:0] S_ANG_WAIT = 4'd4;
	localparam logic [3:0] S_MUL      = 4'd5;
	localparam logic [3:0] S_COS      = 4'd6;
	localparam logic [3:0] S_RMW_RD   = 4'd7;
	localparam logic [3:0] S_RMW_WR   = 4'd8;
	localparam logic [3:0] S_RD_A     = 4'd9;
	localparam logic [3:0] S_RD_B     = 4'd10;
	localparam logic [3:0] S_RD_C     = 4'd11;
	localparam logic [3:0] S_ASY      = 4'd12;
	localparam logic [3:0] S_ASY_WAIT = 4'd13;
	localparam logic [3:0] S_OUT      = 4'd14;

	localparam logic [1:0] ANG_EPOL = 2'd0;
	localparam logic [1:0] ANG_PPOL = 2'd1;
	localparam logic [1:0] ANG_AZ   = 2'd2;

	logic [3:0]  state_q;
	cmd_t        cmd_q;
	logic        bin_go_q;
	logic [1:0]  ang_sel_q;
	logic [1:0]  mul_step_q;

	// angle conversion
	logic signed [MAG_W:0]   mrad;
	logic [MAG_W-1:0]        mag;
	logic [34:0]             p1_q;
	logic [20:0]             x_q;
	logic                    sign_q;
	logic [41:0]             q2_full;
	logic [ANG_W-1:0]        zmag;
	logic signed [ANG_W-1:0] z_q;

	// trig results and products
	logic signed [CS_W-1:0]   ce_q, se_q, cp_q, sp_q, cd_q;
	logic signed [CS_W-1:0]   mul_a, mul_b;
	logic signed [2*CS_W-1:0] prod;
	logic signed [2*CS_W-1:0] prod_q;
	logic signed [2*CS_W-1:0] prod_sh;
	logic signed [CS_W:0]     acc_q;
	logic signed [CS_W:0]     sum_q;
	logic signed [CS_W:0]     s16;

	// shared units
	logic                    cordic_busy;
	logic signed [CS_W-1:0]  cordic_cos, cordic_sin;
	logic                    div_start, div_busy;
	logic [DIV_NUM_W-1:0]    div_num, div_quo;
	logic [DIV_DEN_W-1:0]    div_den, div_rem;

	// count stores
	logic [COUNT_WIDTH-1:0] mem_all  [DEPTH];
	logic [COUNT_WIDTH-1:0] mem_near [DEPTH];
	logic [DEPTH-1:0]       vld_all_q, vld_near_q;
	logic [COUNT_WIDTH-1:0] rd_all_q, rd_near_q;
	logic                   rd_vall_q, rd_vnear_q;
	logic                   rd_en;
	logic [ADDR_W-1:0]      rd_addr;
	logic [ADDR_W-1:0]      k_q;
	logic [ADDR_W-1:0]      src_base;
	logic [COUNT_WIDTH-1:0] cur_all, cur_near, cur_sel;
	logic                   wr_all, wr_near;

	// readout
	logic [CNT_OUT_W-1:0] a_q, b_q;
	logic [CNT_OUT_W-1:0] ab_diff;

	// working result and output register
	logic                    passed_q, near_q;
	logic [BIN_IDX_W-1:0]    bin_hit_q;
	logic [COS_W-1:0]        cosq_q;
	logic [CNT_OUT_W-1:0]    cnt_q;
	logic signed [ASY_W-1:0] asy_q;
	logic                    out_valid_q;
	logic                    out_free;

	pec_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == S_ANG_GO),
		.z_in    (z_q),
		.busy    (cordic_busy),
		.cos_out (cordic_cos),
		.sin_out (cordic_sin)
	);

	pec_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	assign pop      = (state_q == S_IDLE) && head_valid;
	assign out_free = !out_valid_q || results.ready;
	assign src_base = cmd_q.source ? ADDR_W'(NUM_BINS) : '0;
	assign ab_diff  = (a_q >= b_q) ? (a_q - b_q) : (b_q - a_q);

	// binning divide starts as the event is taken, asymmetry after readout
	always_comb begin
		div_start = 1'b0;
		div_num   = DIV_NUM_W'(head.diff);
		div_den   = DIV_DEN_W'(cfg.bin_width);
		if (state_q == S_ASY) begin
			div_start = (a_q != b_q);
			div_num   = {ab_diff, 15'd0};
			div_den   = {1'b0, a_q} + {1'b0, b_q};
		end else if (pop) begin
			div_start = (head.cmd.opcode == OP_ACC) && head.bin_go;
		end
	end

	always_comb begin
		case (ang_sel_q)
			ANG_EPOL: mrad = $signed({3'b000, cmd_q.electron_polar});
			ANG_PPOL: mrad = $signed({3'b000, cmd_q.positron_polar});
			default:  mrad = (MAG_W+1)'(cmd_q.electron_azimuth)
				- (MAG_W+1)'(cmd_q.positron_azimuth);
		endcase
		mag     = mrad[MAG_W] ? MAG_W'(-mrad) : mrad[MAG_W-1:0];
		q2_full = x_q * RECIP_125;
		zmag    = ANG_W'(p1_q) + ANG_W'(q2_full >> RECIP_SHIFT);
	end

	always_comb begin
		case (mul_step_q)
			2'd0: begin
				mul_a = ce_q;
				mul_b = cp_q;
			end
			2'd1: begin
				mul_a = se_q;
				mul_b = sp_q;
			end
			default: begin
				mul_a = CS_W'(prod_q >>> 30);
				mul_b = cd_q;
			end
		endcase
		prod    = mul_a * mul_b;
		prod_sh = prod_q >>> 30;
		s16     = sum_q >>> 14;
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = k_q;
		case (state_q)
			S_RMW_RD: rd_en = 1'b1;
			S_RD_A: begin
				rd_en   = 1'b1;
				rd_addr = src_base + ADDR_W'(cmd_q.bin_index);
			end
			S_RD_B: begin
				rd_en   = 1'b1;
				rd_addr = src_base + ADDR_W'(NUM_BINS - 1) - ADDR_W'(cmd_q.bin_index);
			end
			default: ;
		endcase
		cur_all  = rd_vall_q ? rd_all_q : '0;
		cur_near = rd_vnear_q ? rd_near_q : '0;
		cur_sel  = cmd_q.window_select ? cur_near : cur_all;
		wr_all   = (state_q == S_RMW_WR);
		wr_near  = (state_q == S_RMW_WR) && near_q;
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_all_q   <= mem_all[rd_addr];
			rd_near_q  <= mem_near[rd_addr];
			rd_vall_q  <= vld_all_q[rd_addr];
			rd_vnear_q <= vld_near_q[rd_addr];
		end
		if (wr_all) begin
			mem_all[k_q] <= (cur_all == CNT_MAX) ? cur_all : cur_all + 1'b1;
		end
		if (wr_near) begin
			mem_near[k_q] <= (cur_near == CNT_MAX) ? cur_near : cur_near + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			vld_all_q   <= '0;
			vld_near_q  <= '0;
			ang_sel_q   <= ANG_EPOL;
			mul_step_q  <= 2'd0;
		end else begin
			if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: if (head_valid) begin
					case (head.cmd.opcode)
						OP_ACC:   state_q <= S_ANG_MUL;
						OP_READ:  state_q <= ({1'b0, head.cmd.bin_index}
							< (BIN_IDX_W+1)'(NUM_BINS)) ? S_RD_A : S_OUT;
						OP_CLEAR: begin
							vld_all_q  <= '0;
							vld_near_q <= '0;
							state_q    <= S_OUT;
						end
						default:  state_q <= S_OUT;
					endcase
					ang_sel_q <= ANG_EPOL;
				end
				S_ANG_MUL:  state_q <= S_ANG_SUM;
				S_ANG_SUM:  state_q <= S_ANG_GO;
				S_ANG_GO:   state_q <= S_ANG_WAIT;
				S_ANG_WAIT: if (!cordic_busy) begin
					if (ang_sel_q == ANG_AZ) begin
						state_q    <= S_MUL;
						mul_step_q <= 2'd0;
					end else begin
						ang_sel_q <= ang_sel_q + 1'b1;
						state_q   <= S_ANG_MUL;
					end
				end
				S_MUL: begin
					mul_step_q <= mul_step_q + 1'b1;
					if (mul_step_q == 2'd3) begin
						state_q <= S_COS;
					end
				end
				S_COS: if (!(bin_go_q && div_busy)) begin
					if (bin_go_q && (div_rem != '0)
						&& (div_quo < DIV_NUM_W'(NUM_BINS))) begin
						state_q <= S_RMW_RD;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_RMW_RD: state_q <= S_RMW_WR;
				S_RMW_WR: begin
					vld_all_q[k_q] <= 1'b1;
					if (near_q) begin
						vld_near_q[k_q] <= 1'b1;
					end
					state_q <= S_OUT;
				end
				S_RD_A: state_q <= S_RD_B;
				S_RD_B: state_q <= S_RD_C;
				S_RD_C: state_q <= S_ASY;
				S_ASY:  state_q <= (a_q == b_q) ? S_OUT : S_ASY_WAIT;
				S_ASY_WAIT: if (!div_busy) begin
					state_q <= S_OUT;
				end
				S_OUT: if (out_free) begin
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (head_valid) begin
				cmd_q     <= head.cmd;
				bin_go_q  <= head.bin_go;
				passed_q  <= 1'b0;
				near_q    <= 1'b0;
				bin_hit_q <= '0;
				cosq_q    <= '0;
				cnt_q     <= '0;
				asy_q     <= '0;
			end
			S_ANG_MUL: begin
				p1_q   <= mag * MRAD_HI;
				x_q    <= mag * MRAD_LO;
				sign_q <= mrad[MAG_W];
			end
			S_ANG_SUM: z_q <= sign_q ? -$signed(zmag) : $signed(zmag);
			S_ANG_WAIT: if (!cordic_busy) begin
				case (ang_sel_q)
					ANG_EPOL: begin
						ce_q <= cordic_cos;
						se_q <= cordic_sin;
					end
					ANG_PPOL: begin
						cp_q <= cordic_cos;
						sp_q <= cordic_sin;
					end
					default: cd_q <= cordic_cos;
				endcase
			end
			S_MUL: begin
				prod_q <= prod;
				if (mul_step_q == 2'd1) begin
					acc_q <= (CS_W+1)'(prod_sh);
				end
				if (mul_step_q == 2'd3) begin
					sum_q <= acc_q + (CS_W+1)'(prod_sh);
				end
			end
			S_COS: begin
				if (s16 < 0) begin
					cosq_q <= '0;
					near_q <= (COS_W'(0) >= cfg.cos_outer) && (COS_W'(0) < cfg.cos_inner);
				end else if (s16 > $signed((CS_W+1)'(COS_ONE))) begin
					cosq_q <= COS_ONE;
					near_q <= (COS_ONE >= cfg.cos_outer) && (COS_ONE < cfg.cos_inner);
				end else begin
					cosq_q <= s16[COS_W-1:0];
					near_q <= (s16[COS_W-1:0] >= cfg.cos_outer)
						&& (s16[COS_W-1:0] < cfg.cos_inner);
				end
				k_q <= src_base + ADDR_W'(div_quo);
			end
			S_RMW_WR: begin
				passed_q  <= 1'b1;
				bin_hit_q <= BIN_IDX_W'(div_quo);
			end
			S_RD_B: a_q <= CNT_OUT_W'(cur_sel);
			S_RD_C: begin
				b_q   <= CNT_OUT_W'(cur_sel);
				cnt_q <= a_q;
			end
			S_ASY_WAIT: if (!div_busy) begin
				if (div_quo > DIV_NUM_W'(ASY_MAX)) begin
					asy_q <= (a_q >= b_q) ? $signed(ASY_MAX) : -$signed(ASY_MAX);
				end else begin
					asy_q <= (a_q >= b_q) ? $signed(div_quo[ASY_W-1:0])
						: -$signed(div_quo[ASY_W-1:0]);
				end
			end
			S_OUT: if (out_free) begin
				results.passed         <= passed_q;
				results.bin_hit        <= bin_hit_q;
				results.near_angle     <= near_q;
				results.opening_cosine <= cosq_q;
				results.bin_count      <= cnt_q;
				results.asymmetry      <= asy_q;
			end
			default: ;
		endcase
	end

	assign results.valid = out_valid_q;

endmodule

@@ rtl/pair_event_cut_histogrammer_core.sv @@
// ----------------------------------------------------------------------------
// pair_event_cut_histogrammer_core
// pair-event energy cuts, difference histogram, opening-angle window, readout
// ----------------------------------------------------------------------------
// One item beat is one command. An accumulate runs three sine/cosine
// evaluations one after another on the single iterative CORDIC unit; the
// binning divide runs alongside them. A read runs the asymmetry divide
// unless the two counts are equal; a clear, an unused opcode or a read
// beyond the last bin goes straight to the result beat. The front queue
// holds two beats, so the item side can take up to two beats while the back
// end works or a result beat waits. Counts sit in two on-chip stores of
// 2*NUM_BINS words with a valid bit per word; reset and clear drop the valid
// bits at once, no sweep needed. Configuration writes are always taken and
// must only come while idle.
// ----------------------------------------------------------------------------
module pair_event_cut_histogrammer_core import pec_pkg::*; #(
	parameter int NUM_BINS     = DEF_NUM_BINS,
	parameter int COUNT_WIDTH  = DEF_COUNT_WIDTH,
	parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
	input logic clk,
	input logic arst_n,
	pec_cfg_if.sink      cfg,
	pec_item_if.sink     items,
	pec_result_if.source results
);

	// configuration registers
	cfg_t cfg_q;

	// front to back
	ent_t head;
	logic head_valid;
	logic pop;

	assign cfg.ready = 1'b1;

	// register writes, masked to each register's width; unknown index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.energy_min  <= RST_ENERGY_MIN;
			cfg_q.sum_low     <= RST_SUM_LOW;
			cfg_q.sum_high    <= RST_SUM_HIGH;
			cfg_q.bin_width   <= RST_BIN_WIDTH;
			cfg_q.diff_offset <= RST_DIFF_OFFSET;
			cfg_q.cos_outer   <= RST_COS_OUTER;
			cfg_q.cos_inner   <= RST_COS_INNER;
		end else if (cfg.valid) begin
			case (cfg.idx)
				REG_ENERGY_MIN:  cfg_q.energy_min  <= cfg.wdata[ENERGY_W-1:0];
				REG_SUM_LOW:     cfg_q.sum_low     <= cfg.wdata[SUM_W-1:0];
				REG_SUM_HIGH:    cfg_q.sum_high    <= cfg.wdata[SUM_W-1:0];
				REG_BIN_WIDTH:   cfg_q.bin_width   <= cfg.wdata[ENERGY_W-1:0];
				REG_DIFF_OFFSET: cfg_q.diff_offset <= cfg.wdata[SUM_W-1:0];
				REG_COS_OUTER:   cfg_q.cos_outer   <= cfg.wdata[COS_W-1:0];
				REG_COS_INNER:   cfg_q.cos_inner   <= cfg.wdata[COS_W-1:0];
				default: ;
			endcase
		end
	end

	// front: take beats, apply the energy cuts, queue
	pec_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.items      (items),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	// back: angle math, binning, stores, readout, result register
	pec_back #(
		.NUM_BINS     (NUM_BINS),
		.COUNT_WIDTH  (COUNT_WIDTH),
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.results    (results)
	);

	// a hit bin always lies inside the histogram
	a_bin_range: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.passed
		|-> {1'b0, results.bin_hit} < (BIN_IDX_W+1)'(NUM_BINS))
		else $error("bin_hit beyond histogram");

	// readout fields and accumulate fields never mix in one beat
	a_fields_apart: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && (results.bin_count != '0 || results.asymmetry != '0)
		|-> !results.passed && !results.near_angle && results.opening_cosine == '0)
		else $error("read and accumulate fields mixed");

	// opening cosine stays clamped
	a_cos_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> results.opening_cosine <= COS_ONE)
		else $error("opening cosine above one");

	// a passed beat carries no bin count, since only accumulates pass
	a_pass_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.passed |-> results.bin_count == '0)
		else $error("passed set on a readout");

endmodule

@@ tb/tb_pair_event_cut_histogrammer_core.sv @@
// ----------------------------------------------------------------------------
// tb_pair_event_cut_histogrammer_core
// self-checking bench: directed and random pair events, reads and clears on the
// item channel, register settings on the config channel; every result beat is
// compared against a bit-true model of cuts, cordic opening angle and stores
// ----------------------------------------------------------------------------
module tb_pair_event_cut_histogrammer_core import pec_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NBINS = DEF_NUM_BINS;
	localparam int NSTEPS = DEF_CORDIC_STEPS;
	localparam int NREGS = 7;
	// index past the register list, the block must ignore it
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int IDLE_PAUSE = 300;
	localparam int STALL_LIMIT = 20000;
	localparam int LONG_HOLD = 800;
	localparam int RAND_PER_PHASE = 300;

	localparam longint PI_Q30 = 64'sd3373259426;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint TWO_PI_Q30 = 64'sd6746518852;
	localparam longint GAIN_Q30 = 64'sd652032874;
	localparam longint ARCTAN_Q30 [24] = '{
		843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
		16775850, 8388437, 4194282, 2097149, 1048575, 524287,
		262143, 131071, 65535, 32767, 16383, 8191,
		4095, 2047, 1023, 511, 255, 127};

	typedef struct {
		logic                    passed;
		logic [BIN_IDX_W-1:0]    bin_hit;
		logic                    near_angle;
		logic [COS_W-1:0]        opening_cosine;
		logic [CNT_OUT_W-1:0]    bin_count;
		logic signed [ASY_W-1:0] asymmetry;
	} outcome_t;

	logic clk;
	logic arst_n;

	pec_cfg_if    cfg_ch();
	pec_item_if   item_ch();
	pec_result_if res_ch();

	pair_event_cut_histogrammer_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.items(item_ch),
		.results(res_ch)
	);

	// model state: register copies and both count stores
	longint reg_val [NREGS];
	longint all_counts [2*NBINS];
	longint near_counts [2*NBINS];

	cmd_t     pending_cmds [$];
	outcome_t expected_outcomes [$];
	int       error_count;
	bit       hold_request;
	bit       gapless;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// ------------------------------------------------------------------
	// bit-true model
	// ------------------------------------------------------------------
	function automatic void cordic_sincos(input longint mrad, output longint c,
			output longint s);
		longint z, x, y, xs, ys, mag;
		bit fold;
		mag = (mrad < 0) ? -mrad : mrad;
		z = (mag * (64'sd1 <<< 30)) / 1000;
		if (mrad < 0)
			z = -z;
		x = GAIN_Q30;
		y = 0;
		fold = 1'b0;
		while (z > PI_Q30) z -= TWO_PI_Q30;
		while (z < -PI_Q30) z += TWO_PI_Q30;
		// fold into the right half plane, sine and cosine flip sign
		if (z > HALF_PI_Q30) begin
			z -= PI_Q30;
			fold = 1'b1;
		end else if (z < -HALF_PI_Q30) begin
			z += PI_Q30;
			fold = 1'b1;
		end
		for (int i = 0; i < NSTEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys;
				y += xs;
				z -= ARCTAN_Q30[i];
			end else begin
				x += ys;
				y -= xs;
				z += ARCTAN_Q30[i];
			end
		end
		c = fold ? -x : x;
		s = fold ? -y : y;
	endfunction

	function automatic longint opening_angle_cos(input cmd_t cmd);
		longint ce, se, cp, sp, cd, sd, t, acc;
		cordic_sincos(longint'(cmd.electron_polar), ce, se);
		cordic_sincos(longint'(cmd.positron_polar), cp, sp);
		cordic_sincos(longint'(cmd.electron_azimuth) - longint'(cmd.positron_azimuth),
			cd, sd);
		t = (se * sp) >>> 30;
		acc = ((ce * cp) >>> 30) + ((t * cd) >>> 30);
		acc = acc >>> 14;
		if (acc < 0)
			acc = 0;
		if (acc > 65536)
			acc = 65536;
		return acc;
	endfunction

	function automatic void bump_count(ref longint cnt);
		if (cnt < 64'hFFFF_FFFF)
			cnt++;
	endfunction

	// advance the histogram state by one command, return the result beat
	function automatic outcome_t histogram_step(input cmd_t cmd);
		outcome_t o;
		longint ep, ee, esum, cosq, d, n, a, b, asy;
		int k;
		bit near;
		o = '{default: '0};
		ep = cmd.positron_energy;
		ee = cmd.electron_energy;
		case (cmd.opcode)
			OP_ACC: begin
				cosq = opening_angle_cos(cmd);
				esum = ep + ee;
				near = (cosq >= reg_val[REG_COS_OUTER]) && (cosq < reg_val[REG_COS_INNER]);
				o.near_angle = near;
				o.opening_cosine = cosq[COS_W-1:0];
				if (ep > reg_val[REG_ENERGY_MIN] && ee > reg_val[REG_ENERGY_MIN]
						&& esum > reg_val[REG_SUM_LOW] && esum < reg_val[REG_SUM_HIGH]
						&& reg_val[REG_BIN_WIDTH] != 0) begin
					d = ee - ep + reg_val[REG_DIFF_OFFSET];
					// bin edges, non-positive and overflowing differences count nothing
					if (d > 0 && (d % reg_val[REG_BIN_WIDTH]) != 0) begin
						n = d / reg_val[REG_BIN_WIDTH];
						if (n < NBINS) begin
							k = int'(cmd.source) * NBINS + int'(n);
							bump_count(all_counts[k]);
							if (near)
								bump_count(near_counts[k]);
							o.passed = 1'b1;
							o.bin_hit = n[BIN_IDX_W-1:0];
						end
					end
				end
			end
			OP_READ: begin
				if (cmd.bin_index < NBINS) begin
					k = int'(cmd.source) * NBINS;
					if (cmd.window_select) begin
						a = near_counts[k + cmd.bin_index];
						b = near_counts[k + NBINS - 1 - cmd.bin_index];
					end else begin
						a = all_counts[k + cmd.bin_index];
						b = all_counts[k + NBINS - 1 - cmd.bin_index];
					end
					asy = 0;
					if (a != b) begin
						asy = ((a - b) * 32768) / (a + b);
						if (asy > 32767)
							asy = 32767;
						if (asy < -32767)
							asy = -32767;
					end
					o.bin_count = a[CNT_OUT_W-1:0];
					o.asymmetry = asy[ASY_W-1:0];
				end
			end
			OP_CLEAR: begin
				foreach (all_counts[i]) begin
					all_counts[i] = 0;
					near_counts[i] = 0;
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	// ------------------------------------------------------------------
	// item driver
	// ------------------------------------------------------------------
	cmd_t driven_cmd;
	int   send_gap;

	always @(posedge clk or negedge arst_n) begin
		cmd_t nxt;
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
			send_gap <= 0;
		end else begin
			// an accepted beat updates the model in acceptance order
			if (item_ch.valid && item_ch.ready)
				expected_outcomes.push_back(histogram_step(driven_cmd));
			if (!item_ch.valid || item_ch.ready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					item_ch.valid <= 1'b0;
				end else if (pending_cmds.size() > 0) begin
					nxt = pending_cmds.pop_front();
					driven_cmd <= nxt;
					item_ch.valid <= 1'b1;
					item_ch.opcode <= nxt.opcode;
					item_ch.src <= nxt.source;
					item_ch.positron_energy <= nxt.positron_energy;
					item_ch.electron_energy <= nxt.electron_energy;
					item_ch.electron_polar <= nxt.electron_polar;
					item_ch.positron_polar <= nxt.positron_polar;
					item_ch.electron_azimuth <= nxt.electron_azimuth;
					item_ch.positron_azimuth <= nxt.positron_azimuth;
					item_ch.bin_index <= nxt.bin_index;
					item_ch.window_select <= nxt.window_select;
					send_gap <= gapless ? 0 : $urandom_range(0, 5);
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// result monitor with its own back-pressure
	// ------------------------------------------------------------------
	int recv_stall;

	always @(posedge clk or negedge arst_n) begin
		outcome_t exp_o;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			recv_stall <= 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (expected_outcomes.size() == 0) begin
					$error("result beat with nothing expected");
					error_count++;
				end else begin
					exp_o = expected_outcomes.pop_front();
					if (res_ch.passed !== exp_o.passed) begin
						$error("passed: expected %0d, got %0d", exp_o.passed, res_ch.passed);
						error_count++;
					end
					if (res_ch.bin_hit !== exp_o.bin_hit) begin
						$error("bin_hit: expected %0d, got %0d", exp_o.bin_hit, res_ch.bin_hit);
						error_count++;
					end
					if (res_ch.near_angle !== exp_o.near_angle) begin
						$error("near_angle: expected %0d, got %0d", exp_o.near_angle,
							res_ch.near_angle);
						error_count++;
					end
					if (res_ch.opening_cosine !== exp_o.opening_cosine) begin
						$error("opening_cosine: expected %0d, got %0d", exp_o.opening_cosine,
							res_ch.opening_cosine);
						error_count++;
					end
					if (res_ch.bin_count !== exp_o.bin_count) begin
						$error("bin_count: expected %0d, got %0d", exp_o.bin_count,
							res_ch.bin_count);
						error_count++;
					end
					if (res_ch.asymmetry !== exp_o.asymmetry) begin
						$error("asymmetry: expected %0d, got %0d", exp_o.asymmetry,
							res_ch.asymmetry);
						error_count++;
					end
				end
			end
			// a long hold-off lets the front queue fill and stall the item side
			if (hold_request) begin
				hold_request = 1'b0;
				recv_stall <= LONG_HOLD;
				res_ch.ready <= 1'b0;
			end else if (recv_stall > 0) begin
				recv_stall <= recv_stall - 1;
				res_ch.ready <= 1'b0;
			end else if (res_ch.valid && res_ch.ready) begin
				if (gapless) begin
					res_ch.ready <= 1'b1;
				end else begin
					recv_stall <= $urandom_range(0, 5);
					res_ch.ready <= 1'b0;
				end
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// watchdog: cycles without any beat on any channel
	// ------------------------------------------------------------------
	int quiet_cycles;

	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	function automatic cmd_t pair_event(input logic src, input longint ep, input longint ee,
			input longint pe, input longint pp, input longint ae, input longint ap);
		cmd_t c;
		c = '0;
		c.opcode = OP_ACC;
		c.source = src;
		c.positron_energy = ep[ENERGY_W-1:0];
		c.electron_energy = ee[ENERGY_W-1:0];
		c.electron_polar = pe[POLAR_W-1:0];
		c.positron_polar = pp[POLAR_W-1:0];
		c.electron_azimuth = ae[AZ_W-1:0];
		c.positron_azimuth = ap[AZ_W-1:0];
		// noise in fields the block ignores for this opcode
		c.bin_index = $urandom_range(0, 63);
		c.window_select = $urandom_range(0, 1);
		return c;
	endfunction

	function automatic cmd_t bin_read(input logic src, input int bi, input logic ws);
		cmd_t c;
		c = pair_event(src, $urandom_range(0, 65535), $urandom_range(0, 65535),
			$urandom_range(0, 3142), $urandom_range(0, 3142), 0, 0);
		c.opcode = OP_READ;
		c.bin_index = bi[BIN_IDX_W-1:0];
		c.window_select = ws;
		return c;
	endfunction

	function automatic longint rand_span(input longint lo, input longint hi);
		if (hi <= lo)
			return lo;
		return lo + longint'($urandom_range(0, 32'(hi - lo)));
	endfunction

	function automatic longint rand_azimuth();
		return longint'($urandom_range(0, 6284)) - 3142;
	endfunction

	// random command shaped so most events clear the cuts for the current registers
	function automatic cmd_t random_command();
		cmd_t c;
		longint s, ep, ee, pe, pp, ae;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			s = rand_span(reg_val[REG_SUM_LOW] + 1, reg_val[REG_SUM_HIGH] - 1);
			ep = rand_span(reg_val[REG_ENERGY_MIN] + 1, s - reg_val[REG_ENERGY_MIN] - 1);
			if (ep > 65535)
				ep = 65535;
			ee = s - ep;
			if (ee > 65535 || ee < 0)
				ee = $urandom_range(0, 65535);
			pe = $urandom_range(0, 3142);
			ae = rand_azimuth();
			if ($urandom_range(0, 1)) begin
				// near the opening-angle window
				pp = pe + $urandom_range(140, 210);
				if (pp > 3142)
					pp = pe - $urandom_range(140, 210);
				c = pair_event($urandom_range(0, 1), ep, ee, pe, pp, ae,
					ae + $urandom_range(0, 40) - 20);
				if (c.positron_azimuth > 3142 || c.positron_azimuth < -3142)
					c.positron_azimuth = ae[AZ_W-1:0];
			end else begin
				c = pair_event($urandom_range(0, 1), ep, ee, pe, $urandom_range(0, 3142), ae,
					rand_azimuth());
			end
		end else if (pick < 90) begin
			c = bin_read($urandom_range(0, 1), ($urandom_range(0, 9) == 0)
				? $urandom_range(0, 63) : $urandom_range(0, NBINS - 1), $urandom_range(0, 1));
		end else if (pick < 92) begin
			c = bin_read($urandom_range(0, 1), 0, 0);
			c.opcode = OP_CLEAR;
		end else if (pick < 94) begin
			c = bin_read($urandom_range(0, 1), 0, 0);
			c.opcode = OP_NOP;
		end else begin
			c = pair_event($urandom_range(0, 1), $urandom_range(0, 65535),
				$urandom_range(0, 65535), $urandom_range(0, 3142), $urandom_range(0, 3142),
				rand_azimuth(), rand_azimuth());
		end
		return c;
	endfunction

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input longint value);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.idx <= idx;
		cfg_ch.wdata <= value[CFG_DATA_W-1:0];
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		case (idx)
			REG_ENERGY_MIN, REG_BIN_WIDTH: reg_val[idx] = value & 64'hFFFF;
			REG_SUM_LOW, REG_SUM_HIGH, REG_DIFF_OFFSET,
			REG_COS_OUTER, REG_COS_INNER: reg_val[idx] = value & 64'h1FFFF;
			default: ;
		endcase
	endtask

	// sampled away from the rising edge so driver updates have settled
	task automatic drain();
		do @(negedge clk);
		while (!(pending_cmds.size() == 0 && !item_ch.valid && expected_outcomes.size() == 0));
		repeat (IDLE_PAUSE) @(posedge clk);
	endtask

	task automatic random_phase(input int count);
		for (int i = 0; i < count; i++) begin
			// occasional stretches with no idling on either side
			if (i % 100 == 0)
				gapless = ($urandom_range(0, 2) == 0);
			pending_cmds.push_back(random_command());
			if (pending_cmds.size() > 8)
				wait (pending_cmds.size() <= 2);
		end
		gapless = 1'b0;
		drain();
	endtask

	// ------------------------------------------------------------------
	// sequence of phases
	// ------------------------------------------------------------------
	initial begin
		error_count = 0;
		hold_request = 1'b0;
		gapless = 1'b0;
		quiet_cycles = 0;
		cfg_ch.valid = 1'b0;
		cfg_ch.idx = '0;
		cfg_ch.wdata = '0;
		item_ch.valid = 1'b0;
		item_ch.opcode = OP_NOP;
		item_ch.src = 1'b0;
		item_ch.positron_energy = '0;
		item_ch.electron_energy = '0;
		item_ch.electron_polar = '0;
		item_ch.positron_polar = '0;
		item_ch.electron_azimuth = '0;
		item_ch.positron_azimuth = '0;
		item_ch.bin_index = '0;
		item_ch.window_select = 1'b0;
		res_ch.ready = 1'b0;
		reg_val[REG_ENERGY_MIN] = RST_ENERGY_MIN;
		reg_val[REG_SUM_LOW] = RST_SUM_LOW;
		reg_val[REG_SUM_HIGH] = RST_SUM_HIGH;
		reg_val[REG_BIN_WIDTH] = RST_BIN_WIDTH;
		reg_val[REG_DIFF_OFFSET] = RST_DIFF_OFFSET;
		reg_val[REG_COS_OUTER] = RST_COS_OUTER;
		reg_val[REG_COS_INNER] = RST_COS_INNER;
		foreach (all_counts[i]) begin
			all_counts[i] = 0;
			near_counts[i] = 0;
		end
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part on reset registers
		// difference exactly on a bin edge
		pending_cmds.push_back(pair_event(0, 2950, 2950, 1000, 1174, 0, 0));
		pending_cmds.push_back(pair_event(0, 2900, 3000, 1000, 1174, 100, 100));
		pending_cmds.push_back(pair_event(1, 2900, 3000, 1500, 1330, -200, -190));
		// energy extremes and angle extremes
		pending_cmds.push_back(pair_event(0, 0, 65535, 0, 3142, -3142, 3142));
		pending_cmds.push_back(pair_event(1, 65535, 65535, 3142, 0, 3142, -3142));
		// energy equal to the minimum, sums on both window edges
		pending_cmds.push_back(pair_event(0, 10, 5850, 400, 600, 0, 0));
		pending_cmds.push_back(pair_event(0, 2900, 2900, 2000, 2100, 50, 0));
		pending_cmds.push_back(pair_event(0, 3000, 3000, 2000, 2100, 50, 0));
		// largest difference lands in the last bin, smallest in the first
		pending_cmds.push_back(pair_event(0, 11, 5900, 3142, 3142, 3142, 3142));
		pending_cmds.push_back(pair_event(0, 5950, 11, 300, 470, -3142, -3142));
		pending_cmds.push_back(bin_read(0, 15, 0));
		pending_cmds.push_back(bin_read(0, 15, 1));
		pending_cmds.push_back(bin_read(0, 14, 0));
		pending_cmds.push_back(bin_read(1, 15, 1));
		pending_cmds.push_back(bin_read(0, 29, 0));
		pending_cmds.push_back(bin_read(0, 0, 0));
		// reads beyond the last bin, then a no-op, a clear and reads of the cleared stores
		pending_cmds.push_back(bin_read(0, NBINS, 0));
		pending_cmds.push_back(bin_read(1, 63, 1));
		begin
			cmd_t c;
			c = bin_read(1, 63, 1);
			c.opcode = OP_NOP;
			pending_cmds.push_back(c);
			c.opcode = OP_CLEAR;
			pending_cmds.push_back(c);
		end
		pending_cmds.push_back(bin_read(0, 15, 0));
		pending_cmds.push_back(bin_read(1, 15, 1));
		drain();

		random_phase(RAND_PER_PHASE);

		// wide cuts, narrow bins, every cosine below one near
		write_register(REG_ENERGY_MIN, 0);
		write_register(REG_SUM_LOW, 0);
		write_register(REG_SUM_HIGH, 131070);
		write_register(REG_BIN_WIDTH, 1);
		write_register(REG_DIFF_OFFSET, 0);
		write_register(REG_COS_OUTER, 0);
		write_register(REG_COS_INNER, 65536);
		random_phase(RAND_PER_PHASE / 2);

		// wide bins and a large difference offset
		write_register(REG_BIN_WIDTH, 2000);
		write_register(REG_DIFF_OFFSET, 65536);
		random_phase(RAND_PER_PHASE / 2);

		// receiver holds off while items keep coming
		write_register(REG_ENERGY_MIN, 65535);
		write_register(REG_SUM_LOW, 131070);
		write_register(REG_COS_OUTER, 65536);
		write_register(REG_COS_INNER, 0);
		hold_request = 1'b1;
		for (int i = 0; i < 40; i++)
			pending_cmds.push_back(random_command());
		drain();

		// upper extremes and masking of wide writes, then an ignored index
		write_register(REG_ENERGY_MIN, 500);
		write_register(REG_SUM_LOW, 64'h7FFF_0000 | 2000);
		write_register(REG_SUM_HIGH, 90000);
		write_register(REG_BIN_WIDTH, 65535);
		write_register(REG_DIFF_OFFSET, 131070);
		write_register(REG_COS_OUTER, 60000);
		write_register(REG_COS_INNER, 65000);
		write_register(REG_UNUSED, 64'hFFFF_FFFF);
		random_phase(RAND_PER_PHASE / 2);

		// random settings
		for (int p = 0; p < 3; p++) begin
			write_register(REG_ENERGY_MIN, $urandom_range(0, 2000));
			write_register(REG_SUM_LOW, $urandom_range(0, 10000));
			write_register(REG_SUM_HIGH, $urandom_range(10000, 131070));
			write_register(REG_BIN_WIDTH, $urandom_range(1, 8000));
			write_register(REG_DIFF_OFFSET, $urandom_range(0, 131070));
			write_register(REG_COS_OUTER, $urandom_range(55000, 64500));
			write_register(REG_COS_INNER, $urandom_range(64500, 65536));
			random_phase(RAND_PER_PHASE);
		end

		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

@@ files.f @@
rtl/pec_pkg.sv
rtl/pec_ifs.sv
rtl/pec_front.sv
rtl/pec_cordic.sv
rtl/pec_div.sv
rtl/pec_back.sv
rtl/pair_event_cut_histogrammer_core.sv
tb/tb_pair_event_cut_histogrammer_core.sv
